FILE: rtl/lsm_pkg.sv
`default_nettype none

package lsm_pkg;

    localparam int unsigned WordWidth  = 32;
    localparam int unsigned DepthWidth = 5;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_MATCH = 2'd2,
        REQ_CLEAR = 2'd3
    } lsm_req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } lsm_status_t;

    // Shift command broadcast to every cell of the stack.
    typedef struct packed {
        logic push;
        logic pop;
    } lsm_shift_t;

endpackage

`default_nettype wire

FILE: rtl/lsm_cell.sv
`default_nettype none

module lsm_cell (
    input  wire logic                                    clk,
    input  wire lsm_pkg::lsm_shift_t                     shift,
    input  wire logic signed [lsm_pkg::WordWidth-1:0]    from_above,
    input  wire logic signed [lsm_pkg::WordWidth-1:0]    from_below,
    output logic signed [lsm_pkg::WordWidth-1:0]         word
);

    logic signed [lsm_pkg::WordWidth-1:0] word_reg;

    // A push moves every word one cell deeper; a pop moves every word one cell up.
    always_ff @(posedge clk)
    begin
        if (shift.push)
        begin
            word_reg <= from_above;
        end
        else if (shift.pop)
        begin
            word_reg <= from_below;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

FILE: rtl/lifo_stack_with_pop_until_match_core.sv
// Channel   | Handshake         | Payload
// ----------+-------------------+-------------------------------------------
// request   | in_valid/in_stall | req_type, operand_value
// result    | out_valid/out_stall | status, out_value, depth_after
//
// Push, pop, clear and any request on an empty stack finish without a search; the result
// is registered and shows the cycle after the transaction.
// Pop until match pops one cell per cycle from the top after the transaction, while the
// result is not stalled; the matching word is popped as well.
// Reset empties the stack at once; stored words are not cleared.
// A stalled result holds the block: no new request and no search step until it is taken.
`default_nettype none

module lifo_stack_with_pop_until_match_core #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [1:0]                             req_type,
    input  wire logic signed [lsm_pkg::WordWidth-1:0]   operand_value,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [1:0]                                  status,
    output logic signed [lsm_pkg::WordWidth-1:0]        out_value,
    output logic [lsm_pkg::DepthWidth-1:0]              depth_after
);

    localparam int unsigned CountWidth = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ExtWidth   =
        (CountWidth > lsm_pkg::DepthWidth) ? CountWidth : lsm_pkg::DepthWidth;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } state_t;

    state_t                                  state_reg, state_next;
    logic [CountWidth-1:0]                   count_reg, count_next;
    logic signed [lsm_pkg::WordWidth-1:0]    target_reg, target_next;
    logic                                    out_valid_reg;
    lsm_pkg::lsm_status_t                    status_reg, status_new;
    logic signed [lsm_pkg::WordWidth-1:0]    value_reg, value_new;
    logic [lsm_pkg::DepthWidth-1:0]          depth_reg;
    logic [ExtWidth-1:0]                     count_ext;
    logic                                    load;
    logic                                    out_free;
    logic                                    in_acc;
    lsm_pkg::lsm_shift_t                     shift;
    logic signed [lsm_pkg::WordWidth-1:0]    cell_word [STACK_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic signed [lsm_pkg::WordWidth-1:0] above;
            logic signed [lsm_pkg::WordWidth-1:0] below;
            if (gi == 0)
            begin : g_top
                assign above = operand_value;
            end
            else
            begin : g_inner_above
                assign above = cell_word[gi-1];
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_bottom
                assign below = '0;
            end
            else
            begin : g_inner_below
                assign below = cell_word[gi+1];
            end
            lsm_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .from_above (above),
                .from_below (below),
                .word       (cell_word[gi])
            );
        end
    endgenerate

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        target_next = target_reg;
        shift       = '0;
        load        = 1'b0;
        status_new  = lsm_pkg::ST_OK;
        value_new   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (lsm_pkg::lsm_req_t'(req_type))
                        lsm_pkg::REQ_PUSH:
                        begin
                            load = 1'b1;
                            if (count_reg == CountWidth'(STACK_DEPTH))
                            begin
                                status_new = lsm_pkg::ST_FULL;
                            end
                            else
                            begin
                                shift.push = 1'b1;
                                count_next = count_reg + CountWidth'(1);
                            end
                        end
                        lsm_pkg::REQ_POP:
                        begin
                            load = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_new = lsm_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                shift.pop  = 1'b1;
                                value_new  = cell_word[0];
                                count_next = count_reg - CountWidth'(1);
                            end
                        end
                        lsm_pkg::REQ_MATCH:
                        begin
                            if (count_reg == '0)
                            begin
                                load       = 1'b1;
                                status_new = lsm_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                target_next = operand_value;
                                state_next  = S_SEARCH;
                            end
                        end
                        lsm_pkg::REQ_CLEAR:
                        begin
                            load       = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // One pop per unstalled cycle; ends at a match or when the stack runs dry.
                if (out_free)
                begin
                    shift.pop  = 1'b1;
                    count_next = count_reg - CountWidth'(1);
                    if (cell_word[0] == target_reg)
                    begin
                        load       = 1'b1;
                        value_new  = target_reg;
                        state_next = S_IDLE;
                    end
                    else if (count_reg == CountWidth'(1))
                    begin
                        load       = 1'b1;
                        status_new = lsm_pkg::ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_ext = ExtWidth'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        if (load)
        begin
            status_reg <= status_new;
            value_reg  <= value_new;
            depth_reg  <= count_ext[lsm_pkg::DepthWidth-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_value   = value_reg;
    assign depth_after = depth_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(STACK_DEPTH))
        else $error("stack count exceeds depth");

    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> count_reg != '0)
        else $error("search running on an empty stack");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == lsm_pkg::REQ_CLEAR |=> count_reg == '0)
        else $error("clear left entries on the stack");
`endif

endmodule

`default_nettype wire
